FILE: rtl/five_bin_dft_accumulator_top_defines.svh
// Assertion macros shared by the five-bin DFT accumulator RTL.
// Included by modules that check their own control logic; needs no other file.
`ifndef FIVE_BIN_DFT_ACCUMULATOR_TOP_DEFINES_SVH
`define FIVE_BIN_DFT_ACCUMULATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent and consequent in the same cycle
`define FBDFT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbdft: same-cycle check failed");
// consequent in the cycle after the antecedent
`define FBDFT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbdft: next-cycle check failed");
`else
`define FBDFT_ASSERT_IMP(label, ante, cons)
`define FBDFT_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: rtl/fbdft_pkg.sv
// Types, widths and coefficient table for the five-bin DFT accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package fbdft_pkg;

    localparam int NUM_BINS       = 5;
    localparam int BIN_BITS       = 3;
    localparam int IDX_BITS       = 4;
    localparam int CMD_BITS       = 2;
    localparam int SUM_BITS       = 28;
    localparam int COEF_MAG_BITS  = 11;   // coefficient magnitude, up to 1024
    localparam int QUOT_SHIFT     = 10;   // divide by 1024
    localparam int QUOT_BITS      = SUM_BITS - QUOT_SHIFT;
    localparam int SQ_BITS        = 2 * QUOT_BITS;
    localparam int MAG_BITS       = 34;
    localparam int OUT_TDATA_BITS = 40;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - MAG_BITS - BIN_BITS;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // magnitude codes of the scale-1024 cosine table
    typedef enum logic [2:0] {
        CF_ZERO,
        CF_392,
        CF_724,
        CF_946,
        CF_1024
    } coef_mag_t;

    typedef struct packed {
        logic      neg;
        coef_mag_t mag;
    } coef_sel_t;

    typedef struct packed {
        logic                acc_en;
        logic                clr_all;
        logic                clr_bin;
        logic [BIN_BITS-1:0] bin;
    } bank_ctrl_t;

    // round(1024*cos(2*pi*n/16)) as sign and magnitude code
    function automatic coef_sel_t coef_lookup(input logic [IDX_BITS-1:0] n);
        coef_sel_t c;
        c.neg = 1'b0;
        c.mag = CF_ZERO;
        case (n)
            4'd0:    begin c.neg = 1'b0; c.mag = CF_1024; end
            4'd1:    begin c.neg = 1'b0; c.mag = CF_946;  end
            4'd2:    begin c.neg = 1'b0; c.mag = CF_724;  end
            4'd3:    begin c.neg = 1'b0; c.mag = CF_392;  end
            4'd4:    begin c.neg = 1'b0; c.mag = CF_ZERO; end
            4'd5:    begin c.neg = 1'b1; c.mag = CF_392;  end
            4'd6:    begin c.neg = 1'b1; c.mag = CF_724;  end
            4'd7:    begin c.neg = 1'b1; c.mag = CF_946;  end
            4'd8:    begin c.neg = 1'b1; c.mag = CF_1024; end
            4'd9:    begin c.neg = 1'b1; c.mag = CF_946;  end
            4'd10:   begin c.neg = 1'b1; c.mag = CF_724;  end
            4'd11:   begin c.neg = 1'b1; c.mag = CF_392;  end
            4'd12:   begin c.neg = 1'b0; c.mag = CF_ZERO; end
            4'd13:   begin c.neg = 1'b0; c.mag = CF_392;  end
            4'd14:   begin c.neg = 1'b0; c.mag = CF_724;  end
            default: begin c.neg = 1'b0; c.mag = CF_946;  end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fbdft_bank.sv
// Ten running sums (real and imaginary for five bins) with their
// constant-coefficient multiply-accumulate. Depends on fbdft_pkg.
`default_nettype none

module fbdft_bank #(
    parameter int SAMPLE_BITS = 13
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fbdft_pkg::bank_ctrl_t                ctrl,
    input  logic [fbdft_pkg::IDX_BITS-1:0]       idx,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    output logic signed [fbdft_pkg::SUM_BITS-1:0] rd_re,
    output logic signed [fbdft_pkg::SUM_BITS-1:0] rd_im
);

    import fbdft_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + COEF_MAG_BITS;

    logic signed [PROD_BITS-1:0] se;
    logic signed [PROD_BITS-1:0] p392;
    logic signed [PROD_BITS-1:0] p724;
    logic signed [PROD_BITS-1:0] p946;
    logic signed [PROD_BITS-1:0] p1024;

    logic signed [SUM_BITS-1:0] re_sum_reg  [NUM_BINS];
    logic signed [SUM_BITS-1:0] im_sum_reg  [NUM_BINS];
    logic signed [SUM_BITS-1:0] re_sum_next [NUM_BINS];
    logic signed [SUM_BITS-1:0] im_sum_next [NUM_BINS];

    // the four coefficient magnitudes are shared by all ten products
    always_comb
    begin
        se    = PROD_BITS'(sample);
        p392  = (se <<< 8) + (se <<< 7) + (se <<< 3);
        p724  = (se <<< 9) + (se <<< 7) + (se <<< 6) + (se <<< 4) + (se <<< 2);
        p946  = (se <<< 10) - (se <<< 6) - (se <<< 3) - (se <<< 2) - (se <<< 1);
        p1024 = se <<< 10;
    end

    function automatic logic signed [PROD_BITS-1:0] pick(
        input coef_mag_t                   m,
        input logic signed [PROD_BITS-1:0] a392,
        input logic signed [PROD_BITS-1:0] a724,
        input logic signed [PROD_BITS-1:0] a946,
        input logic signed [PROD_BITS-1:0] a1024
    );
        logic signed [PROD_BITS-1:0] r;
        case (m)
            CF_392:  r = a392;
            CF_724:  r = a724;
            CF_946:  r = a946;
            CF_1024: r = a1024;
            default: r = '0;
        endcase
        return r;
    endfunction

    for (genvar k = 0; k < NUM_BINS; k++)
    begin : g_bin
        logic [IDX_BITS-1:0]          n_re;
        logic [IDX_BITS-1:0]          n_im;
        coef_sel_t                    c_re;
        coef_sel_t                    c_im;
        logic signed [PROD_BITS-1:0]  p_re;
        logic signed [PROD_BITS-1:0]  p_im;

        // phase index (k+1)*n mod 16; the imaginary part uses the cosine a quarter turn ahead (the negated sine)
        assign n_re = IDX_BITS'(idx * IDX_BITS'(k + 1));
        assign n_im = n_re + IDX_BITS'(4);
        assign c_re = coef_lookup(n_re);
        assign c_im = coef_lookup(n_im);
        assign p_re = pick(c_re.mag, p392, p724, p946, p1024);
        assign p_im = pick(c_im.mag, p392, p724, p946, p1024);

        always_comb
        begin
            re_sum_next[k] = re_sum_reg[k];
            im_sum_next[k] = im_sum_reg[k];
            if (ctrl.clr_all || (ctrl.clr_bin && ctrl.bin == BIN_BITS'(k)))
            begin
                re_sum_next[k] = '0;
                im_sum_next[k] = '0;
            end
            else if (ctrl.acc_en)
            begin
                re_sum_next[k] = c_re.neg ? re_sum_reg[k] - SUM_BITS'(p_re)
                                          : re_sum_reg[k] + SUM_BITS'(p_re);
                im_sum_next[k] = c_im.neg ? im_sum_reg[k] - SUM_BITS'(p_im)
                                          : im_sum_reg[k] + SUM_BITS'(p_im);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_BINS; k++)
            begin
                re_sum_reg[k] <= '0;
                im_sum_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_BINS; k++)
            begin
                re_sum_reg[k] <= re_sum_next[k];
                im_sum_reg[k] <= im_sum_next[k];
            end
        end
    end

    // read port for the selected bin
    always_comb
    begin
        rd_re = '0;
        rd_im = '0;
        if (ctrl.bin < BIN_BITS'(NUM_BINS))
        begin
            rd_re = re_sum_reg[ctrl.bin];
            rd_im = im_sum_reg[ctrl.bin];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fbdft_mag.sv
// Squared magnitude of one bin: truncate both sums by 1024 toward zero,
// square, add and saturate to 34 bits. Depends on fbdft_pkg.
`default_nettype none

module fbdft_mag (
    input  logic signed [fbdft_pkg::SUM_BITS-1:0] re,
    input  logic signed [fbdft_pkg::SUM_BITS-1:0] im,
    output logic [fbdft_pkg::MAG_BITS-1:0]        mag
);

    import fbdft_pkg::*;

    logic [QUOT_BITS-1:0] abs_re;
    logic [QUOT_BITS-1:0] abs_im;
    logic [SQ_BITS-1:0]   sq_re;
    logic [SQ_BITS-1:0]   sq_im;
    logic [SQ_BITS:0]     total;

    // bias negative sums so the arithmetic shift truncates toward zero
    function automatic logic [QUOT_BITS-1:0] quot_abs(input logic signed [SUM_BITS-1:0] s);
        logic signed [SUM_BITS-1:0]  biased;
        logic signed [QUOT_BITS-1:0] q;
        biased = s + (s[SUM_BITS-1] ? SUM_BITS'((1 << QUOT_SHIFT) - 1) : SUM_BITS'(0));
        q      = QUOT_BITS'(biased >>> QUOT_SHIFT);
        return q[QUOT_BITS-1] ? QUOT_BITS'(-q) : QUOT_BITS'(q);
    endfunction

    always_comb
    begin
        abs_re = quot_abs(re);
        abs_im = quot_abs(im);
        sq_re  = abs_re * abs_re;
        sq_im  = abs_im * abs_im;
        total  = (SQ_BITS + 1)'(sq_re) + (SQ_BITS + 1)'(sq_im);
        if (total[SQ_BITS:MAG_BITS] != '0)
            mag = '1;
        else
            mag = total[MAG_BITS-1:0];
    end

endmodule

`default_nettype wire

FILE: rtl/five_bin_dft_accumulator_top.sv
// Top level of the five-bin DFT tone detector: input register, command
// decode, output register. Uses fbdft_pkg, fbdft_bank, fbdft_mag and the defines header.
//
// Usage
//   s_axis carries one command word per handshake: tuser holds the command
//   (accumulate, read-and-clear one bin, clear all), tdata the sample index,
//   the signed sample and the bin select. m_axis returns one word for each
//   read of a valid bin: the 34-bit saturated squared magnitude and the bin.
//   Accumulate, clear-all, unused commands and reads of bins 5..7 give no word.
//   A read word taken into the input register has its result loaded into the
//   output register and presented on m_axis. Throughput: one word per cycle
//   on s_axis while no read waits on a stalled m_axis; the multiply-accumulate
//   and magnitude path is combinational between the input and output registers.
//   Reset clears all ten sums and empties both registers.
//   When m_axis stalls with a result pending, one more word is taken into the
//   input register; accumulate and clear words keep flowing past the stalled
//   result, and s_axis_tready drops only when a read sits waiting behind it.
`default_nettype none
`include "five_bin_dft_accumulator_top_defines.svh"

module five_bin_dft_accumulator_top #(
    parameter int SAMPLE_BITS = 13,
    localparam int IN_TDATA_BITS =
        ((fbdft_pkg::IDX_BITS + SAMPLE_BITS + fbdft_pkg::BIN_BITS + 7) / 8) * 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_index, sample, bin_select, zero pad
    input  logic [IN_TDATA_BITS-1:0]              s_axis_tdata,
    // cmd
    input  logic [fbdft_pkg::CMD_BITS-1:0]        s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // magnitude, bin_read, zero pad
    output logic [fbdft_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);

    import fbdft_pkg::*;

    logic                         in_valid_reg;
    cmd_t                         in_cmd_reg;
    logic [IDX_BITS-1:0]          in_idx_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic [BIN_BITS-1:0]          in_bin_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [MAG_BITS-1:0]          out_mag_reg;
    logic [BIN_BITS-1:0]          out_bin_reg;

    logic                         accept;
    logic                         produces;
    logic                         advance;
    bank_ctrl_t                   bank_ctrl;
    logic signed [SUM_BITS-1:0]   rd_re;
    logic signed [SUM_BITS-1:0]   rd_im;
    logic [MAG_BITS-1:0]          mag;

    assign produces      = (in_cmd_reg == CMD_READ) && (in_bin_reg < BIN_BITS'(NUM_BINS));
    // a read waits only for the output register; other words never wait
    assign advance       = in_valid_reg && (!produces || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_cmd_reg    <= cmd_t'(s_axis_tuser);
            in_idx_reg    <= s_axis_tdata[IDX_BITS-1:0];
            in_sample_reg <= s_axis_tdata[IDX_BITS +: SAMPLE_BITS];
            in_bin_reg    <= s_axis_tdata[IDX_BITS + SAMPLE_BITS +: BIN_BITS];
        end
    end

    // command decode
    always_comb
    begin
        bank_ctrl.acc_en  = 1'b0;
        bank_ctrl.clr_all = 1'b0;
        bank_ctrl.clr_bin = 1'b0;
        bank_ctrl.bin     = in_bin_reg;
        unique case (in_cmd_reg)
            CMD_ACC:   bank_ctrl.acc_en  = advance;
            CMD_READ:  bank_ctrl.clr_bin = advance && produces;
            CMD_CLEAR: bank_ctrl.clr_all = advance;
            default:   bank_ctrl.acc_en  = 1'b0;
        endcase
    end

    fbdft_bank #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (bank_ctrl),
        .idx    (in_idx_reg),
        .sample (in_sample_reg),
        .rd_re  (rd_re),
        .rd_im  (rd_im)
    );

    fbdft_mag u_mag (
        .re  (rd_re),
        .im  (rd_im),
        .mag (mag)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (bank_ctrl.clr_bin)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (bank_ctrl.clr_bin)
        begin
            out_mag_reg <= mag;
            out_bin_reg <= in_bin_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, out_bin_reg, out_mag_reg};

    `FBDFT_ASSERT_NXT(a_read_loads_out, bank_ctrl.clr_bin, out_valid_reg)
    `FBDFT_ASSERT_IMP(a_out_from_read, $rose(out_valid_reg), $past(bank_ctrl.clr_bin))
    `FBDFT_ASSERT_NXT(a_hold_waiting_word, in_valid_reg && !advance, in_valid_reg && $stable(in_bin_reg))
    `FBDFT_ASSERT_IMP(a_out_bin_range, out_valid_reg, out_bin_reg < BIN_BITS'(NUM_BINS))

endmodule

`default_nettype wire

FILE: tb/sv/five_bin_dft_accumulator_top_test.sv
// Self-checking testbench for five_bin_dft_accumulator_top: directed table, then random
// sample windows, full-scale hammering and noise, all checked against an in-bench predictor.
// Depends on fbdft_pkg and the top-level RTL only.
`default_nettype none

module five_bin_dft_accumulator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fbdft_pkg::*;

    localparam int SMP_W    = 13;
    localparam int IN_W     = ((IDX_BITS + SMP_W + BIN_BITS + 7) / 8) * 8;
    localparam int IN_PAD   = IN_W - IDX_BITS - SMP_W - BIN_BITS;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam logic [SMP_W-1:0] SMP_MAX  = 13'h0FFF;
    localparam logic [SMP_W-1:0] SMP_MIN  = 13'h1000;
    localparam logic [SMP_W-1:0] SMP_NEG1 = 13'h1FFF;
    localparam longint MAG_CEIL      = (longint'(1) << MAG_BITS) - 1;
    localparam longint NO_TYPED      = -1;
    localparam int     ITEM_TARGET   = 700;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     DRAIN_TAIL    = 8;
    localparam int     DIR_ROWS      = 25;
    localparam int     RUN_LIMIT_NS  = 4_000_000;

    typedef struct packed {
        logic [MAG_BITS-1:0] mag;
        logic [BIN_BITS-1:0] bin;
    } mag_word_t;

    typedef struct packed {
        logic [CMD_BITS-1:0] op;
        logic [IDX_BITS-1:0] idx;
        logic [SMP_W-1:0]    smp;
        logic [BIN_BITS-1:0] bin;
        logic                typed;
        logic [MAG_BITS-1:0] mag;
    } dir_row_t;

    typedef enum int {DRAIN_OPEN, DRAIN_RANDOM, DRAIN_SPARSE} drain_mode_t;
    typedef enum int {SEQ_WINDOW, SEQ_HAMMER, SEQ_NOISE} seq_kind_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_W-1:0]           s_axis_tdata;
    logic [CMD_BITS-1:0]       s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    logic signed [SUM_BITS-1:0] re_acc [NUM_BINS];
    logic signed [SUM_BITS-1:0] im_acc [NUM_BINS];
    mag_word_t mag_expect_q [$];

    int burst_left     = 0;
    int live_items     = 0;
    int err_count      = 0;
    bit drain_hold_req = 1'b0;

    five_bin_dft_accumulator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // 1024*cos(2*pi*n/16), rounded
    function automatic int wave_coef(input logic [IDX_BITS-1:0] n);
        case (n)
            4'd0:    return 1024;
            4'd1:    return 946;
            4'd2:    return 724;
            4'd3:    return 392;
            4'd4:    return 0;
            4'd5:    return -392;
            4'd6:    return -724;
            4'd7:    return -946;
            4'd8:    return -1024;
            4'd9:    return -946;
            4'd10:   return -724;
            4'd11:   return -392;
            4'd12:   return 0;
            4'd13:   return 392;
            4'd14:   return 724;
            default: return 946;
        endcase
    endfunction

    // Update the bin sums for one word; returns 1 when the word yields a magnitude.
    function automatic bit bins_step(input logic [CMD_BITS-1:0] op,
                                     input logic [IDX_BITS-1:0] idx,
                                     input logic [SMP_W-1:0] smp,
                                     input logic [BIN_BITS-1:0] bin,
                                     output mag_word_t res);
        longint s;
        longint q_re;
        longint q_im;
        longint wide;
        logic [IDX_BITS-1:0] n;
        s = longint'($signed(smp));
        res = '0;
        case (op)
            CMD_ACC:
            begin
                for (int k = 0; k < NUM_BINS; k++)
                begin
                    n = 4'((k + 1) * int'(idx));
                    wide = longint'(re_acc[k]) + s * longint'(wave_coef(n));
                    re_acc[k] = wide[SUM_BITS-1:0];
                    wide = longint'(im_acc[k]) + s * longint'(wave_coef(n + 4'd4));
                    im_acc[k] = wide[SUM_BITS-1:0];
                end
            end
            CMD_READ:
            begin
                if (int'(bin) < NUM_BINS)
                begin
                    q_re = longint'(re_acc[bin]) / 1024;
                    q_im = longint'(im_acc[bin]) / 1024;
                    wide = q_re * q_re + q_im * q_im;
                    if (wide > MAG_CEIL)
                        wide = MAG_CEIL;
                    re_acc[bin] = '0;
                    im_acc[bin] = '0;
                    res.mag = wide[MAG_BITS-1:0];
                    res.bin = bin;
                    return 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                for (int k = 0; k < NUM_BINS; k++)
                begin
                    re_acc[k] = '0;
                    im_acc[k] = '0;
                end
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("mismatch at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offer one word in bursts with random gaps; predict once it is taken.
    task automatic offer_word(input logic [CMD_BITS-1:0] op,
                              input logic [IDX_BITS-1:0] idx,
                              input logic [SMP_W-1:0] smp,
                              input logic [BIN_BITS-1:0] bin,
                              input longint typed_mag);
        int gap;
        mag_word_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{IN_PAD{1'b0}}, bin, smp, idx};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        if (bins_step(op, idx, smp, bin, res))
        begin
            if (typed_mag != NO_TYPED)
                res.mag = typed_mag[MAG_BITS-1:0];
            mag_expect_q.push_back(res);
        end
        if (op != CMD_UNUSED && !(op == CMD_READ && int'(bin) >= NUM_BINS))
            live_items++;
    endtask

    initial
    begin : stim
        dir_row_t dir_tab [DIR_ROWS];
        seq_kind_t kind;
        int pick;
        int tone_k;
        int phase;
        int amp;
        int noise;
        int reps;
        int cnt;
        int s;
        logic [IDX_BITS-1:0] h_idx;
        logic [SMP_W-1:0] h_smp;
        bit first_hammer;
        bit hold_done;
        bit pause_done;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ACC;
        for (int k = 0; k < NUM_BINS; k++)
        begin
            re_acc[k] = '0;
            im_acc[k] = '0;
        end

        dir_tab = '{
            '{CMD_READ,   4'd0,  13'd0,    3'd0, 1'b1, 34'd0},
            '{CMD_READ,   4'd0,  13'd0,    3'd4, 1'b1, 34'd0},
            '{CMD_READ,   4'd15, SMP_NEG1, 3'd7, 1'b0, 34'd0},
            '{CMD_UNUSED, 4'd5,  SMP_NEG1, 3'd2, 1'b0, 34'd0},
            '{CMD_ACC,    4'd0,  SMP_MAX,  3'd0, 1'b0, 34'd0},
            '{CMD_ACC,    4'd15, SMP_MIN,  3'd7, 1'b0, 34'd0},
            '{CMD_ACC,    4'd8,  13'd0,    3'd0, 1'b0, 34'd0},
            '{CMD_ACC,    4'd4,  SMP_NEG1, 3'd5, 1'b0, 34'd0},
            '{CMD_ACC,    4'd3,  13'd1234, 3'd1, 1'b0, 34'd0},
            '{CMD_READ,   4'd0,  13'd0,    3'd5, 1'b0, 34'd0},
            '{CMD_UNUSED, 4'd10, SMP_MAX,  3'd0, 1'b0, 34'd0},
            '{CMD_READ,   4'd0,  13'd0,    3'd0, 1'b0, 34'd0},
            '{CMD_READ,   4'd0,  13'd0,    3'd1, 1'b0, 34'd0},
            '{CMD_READ,   4'd0,  13'd0,    3'd2, 1'b0, 34'd0},
            '{CMD_READ,   4'd0,  13'd0,    3'd3, 1'b0, 34'd0},
            '{CMD_ACC,    4'd1,  SMP_MAX,  3'd7, 1'b0, 34'd0},
            '{CMD_READ,   4'd0,  13'd0,    3'd4, 1'b0, 34'd0},
            '{CMD_ACC,    4'd9,  SMP_MIN,  3'd3, 1'b0, 34'd0},
            '{CMD_CLEAR,  4'd6,  SMP_MAX,  3'd1, 1'b0, 34'd0},
            '{CMD_READ,   4'd0,  13'd0,    3'd2, 1'b1, 34'd0},
            '{CMD_ACC,    4'd0,  SMP_MIN,  3'd0, 1'b0, 34'd0},
            '{CMD_ACC,    4'd0,  SMP_MIN,  3'd0, 1'b0, 34'd0},
            // two full-scale negative samples at n=0: real sum -2^23, so 8192 squared
            '{CMD_READ,   4'd0,  13'd0,    3'd0, 1'b1, 34'd67108864},
            '{CMD_READ,   4'd0,  13'd0,    3'd4, 1'b1, 34'd67108864},
            '{CMD_READ,   4'd0,  13'd0,    3'd6, 1'b0, 34'd0}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            offer_word(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].smp, dir_tab[i].bin,
                       dir_tab[i].typed ? longint'(dir_tab[i].mag) : NO_TYPED);

        first_hammer = 1'b1;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        while (live_items < ITEM_TARGET)
        begin
            if (!hold_done && live_items > 200)
            begin
                // stall the result side and keep reading so the input backs up
                hold_done = 1'b1;
                drain_hold_req = 1'b1;
                repeat (3)
                    offer_word(CMD_READ, 4'($urandom), 13'($urandom),
                               3'($urandom_range(0, 4)), NO_TYPED);
            end
            if (!pause_done && live_items > 450)
            begin
                pause_done = 1'b1;
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                while (mag_expect_q.size() != 0)
                    @(posedge clk);
                burst_left = 0;
            end

            pick = first_hammer ? 60 : $urandom_range(0, 99);
            if (pick < 55)
                kind = SEQ_WINDOW;
            else if (pick < 65)
                kind = SEQ_HAMMER;
            else
                kind = SEQ_NOISE;

            case (kind)
                SEQ_WINDOW:
                begin
                    if ($urandom_range(0, 3) == 0)
                        offer_word(CMD_CLEAR, 4'($urandom), 13'($urandom), 3'($urandom),
                                   NO_TYPED);
                    tone_k = $urandom_range(1, 7);
                    phase  = $urandom_range(0, 15);
                    amp    = $urandom_range(0, 4095);
                    noise  = $urandom_range(0, 300);
                    reps   = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
                    repeat (reps)
                    begin
                        for (int n = 0; n < 16; n++)
                        begin
                            s = amp * wave_coef(4'(tone_k * n + phase)) / 1024
                                + int'($urandom_range(0, 2 * noise)) - noise;
                            if (s > 4095)
                                s = 4095;
                            if (s < -4096)
                                s = -4096;
                            offer_word(CMD_ACC, 4'(n), 13'(s), 3'($urandom), NO_TYPED);
                        end
                    end
                    cnt = $urandom_range(1, 5);
                    repeat (cnt)
                        offer_word(CMD_READ, 4'($urandom), 13'($urandom),
                                   ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                               : 3'($urandom_range(0, 4)),
                                   NO_TYPED);
                end
                SEQ_HAMMER:
                begin
                    // full-scale run long enough to wrap the sums or saturate the magnitude
                    h_idx = (first_hammer || $urandom_range(0, 1) == 0) ? 4'd0
                                                                        : 4'($urandom);
                    h_smp = (first_hammer || $urandom_range(0, 1) == 0) ? SMP_MIN : SMP_MAX;
                    cnt   = first_hammer ? 32 : $urandom_range(28, 40);
                    first_hammer = 1'b0;
                    repeat (cnt)
                        offer_word(CMD_ACC, h_idx, h_smp, 3'($urandom), NO_TYPED);
                    for (int b = 0; b < NUM_BINS; b++)
                        offer_word(CMD_READ, 4'($urandom), 13'($urandom), 3'(b), NO_TYPED);
                end
                default:
                begin
                    cnt = $urandom_range(4, 20);
                    repeat (cnt)
                        offer_word(2'($urandom), 4'($urandom), 13'($urandom), 3'($urandom),
                                   NO_TYPED);
                end
            endcase
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (mag_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result side: switch between open, random and sparse stretches; honor a long hold.
    initial
    begin : drain_side
        drain_mode_t mode;
        int stretch_left;
        int hold_left;
        int tick;

        m_axis_tready = 1'b0;
        mode          = DRAIN_OPEN;
        stretch_left  = 0;
        hold_left     = 0;
        tick          = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            tick++;
            if (drain_hold_req)
            begin
                drain_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (stretch_left == 0)
            begin
                mode = drain_mode_t'($urandom_range(0, 2));
                stretch_left = $urandom_range(16, 96);
            end
            stretch_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    DRAIN_OPEN:   m_axis_tready <= 1'b1;
                    DRAIN_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                    default:      m_axis_tready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        mag_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (mag_expect_q.size() == 0)
                flag_mismatch("result word with nothing pending, magnitude",
                              longint'(m_axis_tdata[MAG_BITS-1:0]), 0);
            else
            begin
                want = mag_expect_q.pop_front();
                if (m_axis_tdata[MAG_BITS-1:0] !== want.mag)
                    flag_mismatch("magnitude", longint'(m_axis_tdata[MAG_BITS-1:0]),
                                  longint'(want.mag));
                if (m_axis_tdata[MAG_BITS +: BIN_BITS] !== want.bin)
                    flag_mismatch("bin_read", longint'(m_axis_tdata[MAG_BITS +: BIN_BITS]),
                                  longint'(want.bin));
            end
        end
    end

    initial
    begin : watchdog
        #RUN_LIMIT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/fbdft_pkg.sv
rtl/fbdft_bank.sv
rtl/fbdft_mag.sv
rtl/five_bin_dft_accumulator_top.sv
tb/sv/five_bin_dft_accumulator_top_test.sv
